// ===== design/twm_pkg.sv =====
// Shared types and constants for the trimmed-mean window filter.
`timescale 1ns / 1ps
`default_nettype none

package twm_pkg;

    localparam int SAMPLE_W = 32;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lat_sample;
        logic signed [SAMPLE_W-1:0] lon_sample;
    } t_fix_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lat_filtered;
        logic signed [SAMPLE_W-1:0] lon_filtered;
    } t_fix_out;

    // Per-cycle controls from the sequencer to every lane.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_en;
        logic acc_first;
        logic div_start;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_DIV,
        S_WAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/window_trimmed_mean_filter_unit.sv =====
// Top level: fix sequencer, latitude and longitude lanes, result merge and output register.
//
//  channel   direction  signals                              payload
//  in        input      i_in_valid / o_in_ready / i_in_data  t_fix_in
//  out       output     o_out_valid / i_out_ready / o_out_data t_fix_out
//
// One fix at a time. The first fix after reset fills the whole ring, later fixes write
// a single slot; then a ring scan, a drain and a start step, the divider (three 16-bit
// reciprocal steps, then a wait until both lanes are done) and a load of the output.
// Reset is synchronous; the ring contents need none, as the first fix overwrites them.
// A held result stalls only the final hand-off: the next fix is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module window_trimmed_mean_filter_unit #(
    parameter int WINDOW = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire twm_pkg::t_fix_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output twm_pkg::t_fix_out      o_out_data
);

    import twm_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] LAST  = AW'(WINDOW - 1);
    localparam logic [AW-1:0] SLOT1 = AW'(1 % WINDOW);

    t_state  r_state, n_state;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_wslot;
    logic          r_primed;
    logic          r_acc_vld;
    logic          r_acc_first;
    t_fix_in       r_fix;
    t_fix_out      r_out;
    logic          r_out_valid;

    t_lane_ctl     ctl;
    logic [AW-1:0] waddr;
    logic          in_beat;
    logic          load_out;
    logic          lat_done, lon_done;
    logic signed [SAMPLE_W-1:0] lat_q, lon_q;

    assign in_beat  = i_in_valid && o_in_ready;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = r_primed ? S_WRITE : S_FILL;
            S_FILL:  if (r_idx == LAST) n_state = S_SCAN;
            S_WRITE: n_state = S_SCAN;
            S_SCAN:  if (r_idx == LAST) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DIV;
            S_DIV:   n_state = S_WAIT;
            S_WAIT:  if (lat_done && lon_done) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        ctl           = '0;
        ctl.acc_en    = r_acc_vld;
        ctl.acc_first = r_acc_first;
        waddr         = r_idx;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_FILL:  ctl.wr_en = 1'b1;
            S_WRITE: begin
                ctl.wr_en = 1'b1;
                waddr     = r_wslot;
            end
            S_SCAN:  ctl.rd_en = 1'b1;
            S_DIV:   ctl.div_start = 1'b1;
            S_DRAIN, S_WAIT, S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_wslot     <= '0;
            r_primed    <= 1'b0;
            r_acc_vld   <= 1'b0;
            r_acc_first <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc_vld   <= (r_state == S_SCAN);
            r_acc_first <= (r_state == S_SCAN) && (r_idx == '0);
            if (r_state == S_FILL || r_state == S_SCAN) begin
                r_idx <= (r_idx == LAST) ? '0 : r_idx + 1'b1;
            end
            if (r_state == S_FILL && r_idx == LAST) begin
                r_wslot  <= SLOT1;
                r_primed <= 1'b1;
            end
            if (r_state == S_WRITE) begin
                r_wslot <= (r_wslot == LAST) ? '0 : r_wslot + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the accepted fix, capture the merged result.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_fix <= i_in_data;
        end
        if (load_out) begin
            r_out.lat_filtered <= lat_q;
            r_out.lon_filtered <= lon_q;
        end
    end

    twm_lane #(
        .WINDOW (WINDOW)
    ) u_lat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_waddr  (waddr),
        .i_raddr  (r_idx),
        .i_sample (r_fix.lat_sample),
        .o_done   (lat_done),
        .o_quot   (lat_q)
    );

    twm_lane #(
        .WINDOW (WINDOW)
    ) u_lon (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_waddr  (waddr),
        .i_raddr  (r_idx),
        .i_sample (r_fix.lon_sample),
        .o_done   (lon_done),
        .o_quot   (lon_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/twm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module twm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/twm_div.sv =====
// Reciprocal divider: signed dividend by a constant, quotient toward zero, one digit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module twm_div #(
    parameter int SW      = 36,
    parameter int DIVISOR = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [SW-1:0] i_dividend,
    output logic                      o_done,
    output logic signed [twm_pkg::SAMPLE_W-1:0] o_quot
);

    import twm_pkg::*;

    // Split the magnitude into 16-bit digits, MSB first. Each step divides
    // remainder:digit by a reciprocal multiply that is exact over that range.
    localparam int DIG = 16;
    localparam int ND  = (SW + DIG - 1) / DIG;
    localparam int MW  = ND * DIG;
    localparam int RW  = $clog2(DIVISOR + 1);
    localparam int TW  = DIG + RW;
    localparam int SH  = TW + $clog2(DIVISOR);
    localparam int PW  = 2 * TW + 1;
    localparam int CW  = $clog2(ND + 1);
    localparam longint RECIP =
        ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [PW-1:0] RECIP_C = PW'(RECIP);
    localparam logic [TW-1:0] DIV_C   = TW'(DIVISOR);

    logic [MW-1:0]  r_mag;
    logic [MW-1:0]  r_q;
    logic [RW-1:0]  r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_neg;
    logic           r_busy;
    logic           r_done;

    logic [SW-1:0]  mag;
    logic [TW-1:0]  part;
    logic [PW-1:0]  prod;
    logic [DIG-1:0] q_dig;
    logic [TW-1:0]  q_back;
    logic [MW-1:0]  q_signed;

    assign mag    = i_dividend[SW-1] ? SW'(-i_dividend) : SW'(i_dividend);
    assign part   = {r_rem, r_mag[MW-1 -: DIG]};
    assign prod   = PW'(part) * RECIP_C;
    assign q_dig  = prod[SH +: DIG];
    assign q_back = TW'(q_dig) * DIV_C;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(ND);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // One quotient digit per cycle; carry the remainder into the next digit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= MW'(mag);
            r_q   <= '0;
            r_rem <= '0;
            r_neg <= i_dividend[SW-1];
        end else if (r_busy) begin
            r_mag <= r_mag << DIG;
            r_q   <= {r_q[MW-DIG-1:0], q_dig};
            r_rem <= RW'(part - q_back);
        end
    end

    assign q_signed = r_neg ? (MW'(0) - r_q) : r_q;
    assign o_quot   = q_signed[SAMPLE_W-1:0];
    assign o_done   = r_done;

endmodule

`default_nettype wire

// ===== design/twm_lane.sv =====
// One coordinate lane: sample ring, min/max/sum scan and trimmed-mean divide.
`timescale 1ns / 1ps
`default_nettype none

module twm_lane #(
    parameter int WINDOW = 10
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire twm_pkg::t_lane_ctl                  i_ctl,
    input  wire logic [$clog2(WINDOW)-1:0]           i_waddr,
    input  wire logic [$clog2(WINDOW)-1:0]           i_raddr,
    input  wire logic signed [twm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                     o_done,
    output logic signed [twm_pkg::SAMPLE_W-1:0]      o_quot
);

    import twm_pkg::*;

    localparam int SW = SAMPLE_W + $clog2(WINDOW);

    logic [SAMPLE_W-1:0]        rd_raw;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic signed [SW-1:0]       r_sum;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SW-1:0]       trim;

    twm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_waddr),
        .i_wdata (i_sample),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_raddr),
        .o_rdata (rd_raw)
    );

    assign rd_data = signed'(rd_raw);

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            if (i_ctl.acc_first) begin
                r_sum <= SW'(rd_data);
                r_min <= rd_data;
                r_max <= rd_data;
            end else begin
                r_sum <= r_sum + SW'(rd_data);
                if (rd_data < r_min) begin
                    r_min <= rd_data;
                end
                if (rd_data > r_max) begin
                    r_max <= rd_data;
                end
            end
        end
    end

    // Drop one copy each of the largest and smallest entry.
    assign trim = r_sum - SW'(r_max) - SW'(r_min);

    twm_div #(
        .SW      (SW),
        .DIVISOR (WINDOW - 2)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (trim),
        .o_done     (o_done),
        .o_quot     (o_quot)
    );

endmodule

`default_nettype wire

// ===== verif/window_trimmed_mean_filter_checker.sv =====
// Channel monitor, trimmed-mean predictor and result scoreboard for the window filter.
`timescale 1ns / 1ps

module window_trimmed_mean_filter_checker #(
    parameter int WINDOW = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire twm_pkg::t_fix_in  i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire twm_pkg::t_fix_out i_out_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    import twm_pkg::*;

    typedef logic signed [SAMPLE_W-1:0] t_coord;

    t_coord      lat_ring [WINDOW];
    t_coord      lon_ring [WINDOW];
    int unsigned ring_slot;
    bit          ring_primed;
    t_fix_out    filtered_fix_q [$];
    int          fail_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_count   = 0;
        ring_slot    = 0;
        ring_primed  = 1'b0;
        foreach (lat_ring[i]) begin
            lat_ring[i] = '0;
            lon_ring[i] = '0;
        end
    end

    // Drop one max and one min, even when the extreme value repeats.
    function automatic t_coord trimmed_mean_of(input t_coord ring [WINDOW]);
        longint sum;
        longint lo;
        longint hi;
        sum = 0;
        lo  = ring[0];
        hi  = ring[0];
        for (int i = 0; i < WINDOW; i++) begin
            if (ring[i] < lo) lo = ring[i];
            if (ring[i] > hi) hi = ring[i];
            sum += ring[i];
        end
        return t_coord'((sum - hi - lo) / longint'(WINDOW - 2));
    endfunction

    // First fix after reset fills both rings; later fixes overwrite the oldest slot.
    function automatic void store_fix(input t_fix_in fix);
        if (!ring_primed) begin
            for (int i = 0; i < WINDOW; i++) begin
                lat_ring[i] = fix.lat_sample;
                lon_ring[i] = fix.lon_sample;
            end
            ring_slot   = 1 % WINDOW;
            ring_primed = 1'b1;
        end else begin
            lat_ring[ring_slot] = fix.lat_sample;
            lon_ring[ring_slot] = fix.lon_sample;
            ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
        end
    endfunction

    task automatic check_coord(input string label, input t_coord want, input t_coord got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_fix_out want;
        t_fix_out predicted;
        if (!i_rst_n) begin
            ring_primed = 1'b0;
            ring_slot   = 0;
            filtered_fix_q.delete();
            foreach (lat_ring[i]) begin
                lat_ring[i] = '0;
                lon_ring[i] = '0;
            end
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (filtered_fix_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got lat %0d lon %0d",
                             $time, i_out_data.lat_filtered, i_out_data.lon_filtered);
                end else begin
                    want = filtered_fix_q.pop_front();
                    check_coord("lat_filtered", want.lat_filtered, i_out_data.lat_filtered);
                    check_coord("lon_filtered", want.lon_filtered, i_out_data.lon_filtered);
                end
            end
            if (i_in_valid && i_in_ready) begin
                store_fix(i_in_data);
                predicted.lat_filtered = trimmed_mean_of(lat_ring);
                predicted.lon_filtered = trimmed_mean_of(lon_ring);
                filtered_fix_q.push_back(predicted);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= filtered_fix_q.size();
    end

endmodule

// ===== verif/window_trimmed_mean_filter_unit_tb.sv =====
// Stimulus, clock, reset, watchdog and verdict for the trimmed-mean window filter.
`timescale 1ns / 1ps

module window_trimmed_mean_filter_unit_tb;
    import twm_pkg::*;

    localparam int WINDOW      = 10;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 80;
    localparam int RANDOM_FIXES = 900;
    localparam logic signed [31:0] COORD_MAX = 32'sd1509949440;
    localparam logic signed [31:0] COORD_MIN = -32'sd1509949440;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_fix_in  i_in_data   = '0;
    logic     i_out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_fix_out o_out_data;

    int in_idle_pct  = 38;
    int out_idle_pct = 38;
    int stall_cycles = 0;
    int fail_count;
    int pending;

    always #1 i_clk = ~i_clk;

    window_trimmed_mean_filter_unit #(.WINDOW(WINDOW)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    window_trimmed_mean_filter_checker #(.WINDOW(WINDOW)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side backpressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL window_trimmed_mean_filter_unit");
            $finish;
        end
    end

    // Hold valid and payload until the beat is taken.
    task automatic send_fix(input logic signed [31:0] lat, input logic signed [31:0] lon);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_in_data.lat_sample <= lat;
        i_in_data.lon_sample <= lon;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic signed [31:0] extreme_coord();
        case ($urandom_range(6))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return COORD_MAX;
            3: return COORD_MIN;
            4: return -32'sd1;
            5: return 32'sd1;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [31:0] in_range_coord();
        longint pick;
        pick = longint'($urandom_range(32'd3019898880)) - 64'sd1509949440;
        return pick[31:0];
    endfunction

    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] track);
        int kind;
        kind = $urandom_range(99);
        if (kind < 55) return track + $signed($urandom_range(4000)) - 2000;
        if (kind < 75) return in_range_coord();
        if (kind < 88) return $urandom;
        return extreme_coord();
    endfunction

    initial begin : stimulus
        logic signed [31:0] lat_track;
        logic signed [31:0] lon_track;
        lat_track = 32'sd335544320;
        lon_track = -32'sd1006632960;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First fix fills the whole ring, then range edges and out-of-range patterns.
        send_fix(COORD_MAX, COORD_MIN);
        send_fix(COORD_MIN, COORD_MAX);
        send_fix('0, '0);
        send_fix(32'sh7fffffff, 32'sh80000000);
        send_fix(32'sh80000000, 32'sh7fffffff);
        send_fix(-32'sd1, 32'sd1);
        // Repeated extremes: only one copy of each gets trimmed.
        repeat (4) send_fix(COORD_MAX, COORD_MIN);
        repeat (3) send_fix(COORD_MIN, COORD_MAX);
        // Small mixed-sign windows exercise truncation toward zero.
        send_fix(-32'sd1, 32'sd1);
        send_fix('0, '0);
        send_fix(-32'sd3, 32'sd3);
        send_fix(-32'sd1, 32'sd1);
        repeat (6) send_fix(-32'sd1, 32'sd1);
        send_fix(32'sd5, -32'sd5);
        wait_results_drained();

        for (int n = 0; n < RANDOM_FIXES; n++) begin
            if (n == 300) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            if (n == 480) begin
                in_idle_pct  = 38;
                out_idle_pct = 38;
            end
            if (n == 650) wait_results_drained();
            lat_track = pick_coord(lat_track);
            lon_track = pick_coord(lon_track);
            send_fix(lat_track, lon_track);
        end

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS window_trimmed_mean_filter_unit");
        end else begin
            $display("FAIL window_trimmed_mean_filter_unit");
        end
        $finish;
    end

endmodule
